// ===== rtl/smae_pkg.sv =====
`default_nettype none
package smae_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int DATA_W          = 32;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [2:0] {
    OP_HALT  = 3'd0,
    OP_PRINT = 3'd1,
    OP_CONST = 3'd2,
    OP_NEG   = 3'd3,
    OP_ADD   = 3'd4,
    OP_SUB   = 3'd5,
    OP_MUL   = 3'd6,
    OP_DIV   = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_SAT   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CL_HALT,
    CL_PRINT,
    CL_CONST,
    CL_NEG,
    CL_BIN
  } class_t;

  typedef struct packed {
    opcode_t             op;
    class_t              cls;
    logic [DATA_W-1:0]   cval;
  } item_t;

  // front queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic              print_valid;
    logic              halted;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } sat_t;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] S32_MIN = 64'shffff_ffff_8000_0000;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > S32_MAX) begin
      r.value = 32'h7fff_ffff;
      r.sat   = 1'b1;
    end else if (v < S32_MIN) begin
      r.value = 32'h8000_0000;
      r.sat   = 1'b1;
    end else begin
      r.value = v[31:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/smae_front.sv =====
`default_nettype none
module smae_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [2:0]           in_opcode,
  input  wire logic signed [31:0]   in_const_value,
  output smae_pkg::fq_t             fq,
  input  wire logic                 fq_pop
);

  smae_pkg::item_t q_r [smae_pkg::QUEUE_DEPTH];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  smae_pkg::item_t cls_item;
  smae_pkg::opcode_t op;
  logic            push_ok, pop_ok;

  assign op = smae_pkg::opcode_t'(in_opcode);

  always_comb begin
    cls_item.op   = op;
    cls_item.cval = in_const_value;
    unique case (op) inside
      smae_pkg::OP_HALT:  cls_item.cls = smae_pkg::CL_HALT;
      smae_pkg::OP_PRINT: cls_item.cls = smae_pkg::CL_PRINT;
      smae_pkg::OP_CONST: cls_item.cls = smae_pkg::CL_CONST;
      smae_pkg::OP_NEG:   cls_item.cls = smae_pkg::CL_NEG;
      smae_pkg::OP_ADD, smae_pkg::OP_SUB, smae_pkg::OP_MUL, smae_pkg::OP_DIV:
        cls_item.cls = smae_pkg::CL_BIN;
      default:            cls_item.cls = smae_pkg::CL_HALT;
    endcase
  end

  assign in_full  = (cnt_r == 2'(smae_pkg::QUEUE_DEPTH));
  assign push_ok  = in_push && !in_full;
  assign pop_ok   = fq_pop && (cnt_r != 2'd0);
  assign fq       = {(cnt_r != 2'd0), q_r[rd_ptr_r]};

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/smae_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle, unsigned magnitudes
module smae_div #(
  parameter int FRAC_BITS = smae_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [32+FRAC_BITS-1:0]       dividend,
  input  wire logic [31:0]                   divisor,
  output logic                               done,
  output logic [32+FRAC_BITS-1:0]            quotient
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [32:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [31:0]   div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [32:0]   shifted, trial;
  logic          bit_q;

  assign shifted  = {rem_r[31:0], quo_r[DW-1]};
  assign trial    = shifted - {1'b0, div_r};
  assign bit_q    = !trial[32];
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        rem_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= bit_q ? trial : shifted;
        quo_r <= {quo_r[DW-2:0], bit_q};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/smae_back.sv =====
`default_nettype none
module smae_back #(
  parameter int STACK_DEPTH = smae_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = smae_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire smae_pkg::fq_t fq,
  output logic               fq_pop,
  input  wire logic          out_pop,
  output smae_pkg::res_t     res
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int DPW = $clog2(STACK_DEPTH + 1);
  localparam int DW  = 32 + FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV} state_t;

  state_t          state_r;
  smae_pkg::item_t item_r;
  logic [DPW-1:0]  depth_r;
  logic [31:0]     tos_r;
  logic [31:0]     mem [STACK_DEPTH];
  logic [31:0]     rd_data_r;
  logic            wr_en_r;
  logic [AW-1:0]   wr_addr_r;
  logic [31:0]     wr_data_r;
  logic signed [63:0] prod_r;
  smae_pkg::res_t  res_r;

  logic [DPW-1:0]  dm1, dm2;
  logic [AW-1:0]   top_idx, nos_idx, push_idx;
  logic            d_zero, d_lt2, d_full;
  logic [31:0]     a, b;
  logic [63:0]     ax, bx;
  logic [31:0]     a_mag, b_mag;
  logic            div_neg, div_start, div_done;
  logic [DW-1:0]   div_q;
  logic signed [63:0] qx, mul_sh;
  smae_pkg::sat_t  add_s, sub_s, neg_s, mul_s, div_s;

  assign dm1      = depth_r - DPW'(1);
  assign dm2      = depth_r - DPW'(2);
  assign top_idx  = dm1[AW-1:0];
  assign nos_idx  = dm2[AW-1:0];
  assign push_idx = depth_r[AW-1:0];
  assign d_zero   = (depth_r == '0);
  assign d_lt2    = (depth_r < DPW'(2));
  assign d_full   = (depth_r == DPW'(STACK_DEPTH));

  assign a  = rd_data_r;
  assign b  = tos_r;
  assign ax = {{32{a[31]}}, a};
  assign bx = {{32{b[31]}}, b};

  assign a_mag   = a[31] ? (32'd0 - a) : a;
  assign b_mag   = b[31] ? (32'd0 - b) : b;
  assign div_neg = a[31] ^ b[31];
  assign div_start = (state_r == S_EXEC) && (item_r.cls == smae_pkg::CL_BIN) &&
                     (item_r.op == smae_pkg::OP_DIV) && !d_lt2 && (b != '0);

  assign fq_pop = (state_r == S_IDLE) && fq.valid && !res_r.valid;
  assign res    = res_r;

  smae_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({a_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (b_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    add_s  = smae_pkg::sat32($signed(ax + bx));
    sub_s  = smae_pkg::sat32($signed(ax - bx));
    neg_s  = smae_pkg::sat32($signed(64'd0 - bx));
    mul_sh = prod_r >>> FRAC_BITS;
    mul_s  = smae_pkg::sat32(mul_sh);
    qx     = $signed(64'(div_q));
    div_s  = smae_pkg::sat32(div_neg ? (64'sd0 - qx) : qx);
  end

  // operand stack storage, entry below the cached top is read every cycle
  always_ff @(posedge clk) begin
    if (wr_en_r) mem[wr_addr_r] <= wr_data_r;
    rd_data_r <= mem[nos_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      wr_en_r     <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      wr_en_r <= 1'b0;
      if (out_pop) res_r.valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (fq_pop) begin
            item_r  <= fq.item;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_r.value       <= '0;
          res_r.print_valid <= 1'b0;
          res_r.halted      <= 1'b0;
          res_r.status      <= smae_pkg::ST_OK;
          res_r.valid       <= 1'b1;
          state_r           <= S_IDLE;
          unique case (item_r.cls)
            smae_pkg::CL_HALT: res_r.halted <= 1'b1;
            smae_pkg::CL_PRINT: begin
              if (d_zero) begin
                res_r.status <= smae_pkg::ST_UNDER;
              end else begin
                res_r.value       <= tos_r;
                res_r.print_valid <= 1'b1;
                tos_r             <= rd_data_r;
                depth_r           <= dm1;
              end
            end
            smae_pkg::CL_CONST: begin
              if (d_full) begin
                res_r.status <= smae_pkg::ST_OVER;
              end else begin
                res_r.value <= item_r.cval;
                tos_r       <= item_r.cval;
                wr_en_r     <= 1'b1;
                wr_addr_r   <= push_idx;
                wr_data_r   <= item_r.cval;
                depth_r     <= depth_r + DPW'(1);
              end
            end
            smae_pkg::CL_NEG: begin
              if (d_zero) begin
                res_r.status <= smae_pkg::ST_UNDER;
              end else begin
                res_r.value  <= neg_s.value;
                res_r.status <= neg_s.sat ? smae_pkg::ST_SAT : smae_pkg::ST_OK;
                tos_r        <= neg_s.value;
                wr_en_r      <= 1'b1;
                wr_addr_r    <= top_idx;
                wr_data_r    <= neg_s.value;
              end
            end
            default: begin
              if (d_lt2) begin
                res_r.status <= smae_pkg::ST_UNDER;
              end else begin
                unique case (item_r.op) inside
                  smae_pkg::OP_ADD, smae_pkg::OP_SUB: begin
                    res_r.value  <= (item_r.op == smae_pkg::OP_ADD) ?
                                    add_s.value : sub_s.value;
                    res_r.status <= ((item_r.op == smae_pkg::OP_ADD) ? add_s.sat : sub_s.sat)
                                    ? smae_pkg::ST_SAT : smae_pkg::ST_OK;
                    tos_r        <= (item_r.op == smae_pkg::OP_ADD) ?
                                    add_s.value : sub_s.value;
                    wr_en_r      <= 1'b1;
                    wr_addr_r    <= nos_idx;
                    wr_data_r    <= (item_r.op == smae_pkg::OP_ADD) ?
                                    add_s.value : sub_s.value;
                    depth_r      <= dm1;
                  end
                  smae_pkg::OP_MUL: begin
                    res_r.valid <= 1'b0;
                    prod_r      <= $signed(a) * $signed(b);
                    state_r     <= S_MUL;
                  end
                  default: begin
                    if (b == '0) begin
                      // divide by zero: pops both, pushes zero
                      res_r.status <= smae_pkg::ST_DIVZ;
                      tos_r        <= '0;
                      wr_en_r      <= 1'b1;
                      wr_addr_r    <= nos_idx;
                      wr_data_r    <= '0;
                      depth_r      <= dm1;
                    end else begin
                      res_r.valid <= 1'b0;
                      state_r     <= S_DIV;
                    end
                  end
                endcase
              end
            end
          endcase
        end
        S_MUL: begin
          res_r.value       <= mul_s.value;
          res_r.print_valid <= 1'b0;
          res_r.halted      <= 1'b0;
          res_r.status      <= mul_s.sat ? smae_pkg::ST_SAT : smae_pkg::ST_OK;
          res_r.valid       <= 1'b1;
          tos_r             <= mul_s.value;
          wr_en_r           <= 1'b1;
          wr_addr_r         <= nos_idx;
          wr_data_r         <= mul_s.value;
          depth_r           <= dm1;
          state_r           <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            res_r.value       <= div_s.value;
            res_r.print_valid <= 1'b0;
            res_r.halted      <= 1'b0;
            res_r.status      <= div_s.sat ? smae_pkg::ST_SAT : smae_pkg::ST_OK;
            res_r.valid       <= 1'b1;
            tos_r             <= div_s.value;
            wr_en_r           <= 1'b1;
            wr_addr_r         <= nos_idx;
            wr_data_r         <= div_s.value;
            depth_r           <= dm1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stack_machine_arith_exec_core.sv =====
`default_nettype none
// Stack-machine executor: one instruction word in, one result word out.
// Instruction words are pushed into a two-word front queue (in_full backs
// it up); the back end runs them one at a time against an on-chip operand
// stack of STACK_DEPTH Q(32-FRAC_BITS).FRAC_BITS entries, with the top entry
// cached in a register and the entry below it read from a registered RAM.
// Per word: halt, print, const, negate, add and subtract go from queue head
// to the result register through the idle and execute states; multiply first
// registers the 32x32 product, then applies the floor shift and saturation;
// divide waits on the restoring divider, which yields one quotient bit per
// cycle. A new word starts only once the previous result has been
// popped from the single result register. Errors (underflow, overflow,
// divide by zero) return zero; divide by zero still pops both operands
// and pushes zero. No clearing pass is needed after reset.
module stack_machine_arith_exec_core #(
  parameter int STACK_DEPTH = smae_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = smae_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [2:0]         in_opcode,
  input  wire logic signed [31:0] in_const_value,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output logic signed [31:0]      out_value,
  output logic                    out_print_valid,
  output logic                    out_halted,
  output logic [2:0]              out_status
);

  smae_pkg::fq_t  fq;
  logic           fq_pop;
  smae_pkg::res_t res;

  // front: accept and classify
  smae_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_const_value (in_const_value),
    .fq             (fq),
    .fq_pop         (fq_pop)
  );

  // back: stack, ALU, divider, result register
  smae_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .fq      (fq),
    .fq_pop  (fq_pop),
    .out_pop (out_pop),
    .res     (res)
  );

  assign out_empty       = !res.valid;
  assign out_value       = res.value;
  assign out_print_valid = res.print_valid;
  assign out_halted      = res.halted;
  assign out_status      = res.status;

`ifndef SYNTHESIS
  // a printed word always carries ok status
  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_print_valid) |-> (out_status == smae_pkg::ST_OK))
    else $error("print with non-ok status");

  // halt returns zero
  a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_halted) |-> (out_value == '0))
    else $error("halt with nonzero value");

  // error results return zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status == smae_pkg::ST_UNDER ||
      out_status == smae_pkg::ST_OVER || out_status == smae_pkg::ST_DIVZ))
    |-> (out_value == '0))
    else $error("error result with nonzero value");
`endif

endmodule
`default_nettype wire

// ===== tb/smae_checker.sv =====
module smae_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_const_value,
  input  logic               out_pop,
  input  logic               out_empty,
  input  logic signed [31:0] out_value,
  input  logic               out_print_valid,
  input  logic               out_halted,
  input  logic [2:0]         out_status,
  output int                 fail_count,
  output int                 pending,
  output int                 checked,
  output int                 flagged
);
  timeunit 1ns;
  timeprecision 1ps;
  import smae_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int FRAC  = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] value;
    logic               print_valid;
    logic               halted;
    status_t            status;
  } outcome_t;

  logic signed [31:0] operand_mem [DEPTH];
  int                 sp = 0;
  outcome_t           outcome_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    flagged    = 0;
  end

  function automatic logic signed [31:0] clamp32(input longint v, inout bit hit);
    if (v > longint'(32'sh7fff_ffff)) begin
      hit = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -longint'(64'sd2147483648)) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // one instruction against the shadow operand stack
  task automatic execute_word(input opcode_t op, input logic signed [31:0] cv,
                              output outcome_t r);
    longint a, b, wide;
    bit     hit;
    r.value       = '0;
    r.print_valid = 1'b0;
    r.halted      = 1'b0;
    r.status      = ST_OK;
    hit           = 1'b0;
    case (op)
      OP_HALT: r.halted = 1'b1;
      OP_PRINT: begin
        if (sp < 1) r.status = ST_UNDER;
        else begin
          sp--;
          r.value       = operand_mem[sp];
          r.print_valid = 1'b1;
        end
      end
      OP_CONST: begin
        if (sp >= DEPTH) r.status = ST_OVER;
        else begin
          operand_mem[sp] = cv;
          sp++;
          r.value = cv;
        end
      end
      OP_NEG: begin
        if (sp < 1) r.status = ST_UNDER;
        else begin
          r.value = clamp32(-longint'(operand_mem[sp-1]), hit);
          operand_mem[sp-1] = r.value;
          if (hit) r.status = ST_SAT;
        end
      end
      default: begin
        if (sp < 2) r.status = ST_UNDER;
        else begin
          b = operand_mem[sp-1];
          a = operand_mem[sp-2];
          sp--;
          case (op)
            OP_ADD: wide = a + b;
            OP_SUB: wide = a - b;
            OP_MUL: wide = (a * b) >>> FRAC;   // arithmetic shift = floor
            default: begin
              if (b == 0) begin
                wide     = 0;
                r.status = ST_DIVZ;
              end else wide = (a <<< FRAC) / b;  // truncates toward zero
            end
          endcase
          r.value = clamp32(wide, hit);
          operand_mem[sp-1] = r.value;
          if (r.status == ST_DIVZ) r.value = '0;
          else if (hit) r.status = ST_SAT;
        end
      end
    endcase
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t r;
    if (rst_n) begin
      if (in_push && !in_full) begin
        execute_word(opcode_t'(in_opcode), in_const_value, r);
        outcome_q.push_back(r);
      end
      if (out_pop && !out_empty) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual value %0d status %0d",
                   $time, out_value, out_status);
          fail_count++;
        end else begin
          r = outcome_q.pop_front();
          check_field("value", r.value, out_value);
          check_field("print_valid", r.print_valid, out_print_valid);
          check_field("halted", r.halted, out_halted);
          check_field("status", r.status, out_status);
          checked++;
          if (r.status != ST_OK) flagged++;
        end
      end
      pending = outcome_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smae_pkg::*;

  localparam int N_RANDOM   = 1200;
  localparam int IDLE_LIMIT = 4000;  // well above the receiver hold-off plus a divide
  localparam int HOLD_OFF   = 300;   // long receiver stall to back up the input

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic [2:0]         in_opcode = OP_HALT;
  logic signed [31:0] in_const_value = '0;
  logic               out_pop = 1'b0;
  logic               in_full, out_empty, out_print_valid, out_halted;
  logic signed [31:0] out_value;
  logic [2:0]         out_status;

  int fail_count, pending, checked, flagged;
  int sent = 0;
  int popped = 0;
  int idle_cycles = 0;
  int shadow_depth = 0;  // stimulus-side depth estimate, steers the op mix

  stack_machine_arith_exec_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_const_value(in_const_value),
    .out_pop(out_pop), .out_empty(out_empty),
    .out_value(out_value), .out_print_valid(out_print_valid),
    .out_halted(out_halted), .out_status(out_status)
  );

  smae_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_const_value(in_const_value),
    .out_pop(out_pop), .out_empty(out_empty),
    .out_value(out_value), .out_print_valid(out_print_valid),
    .out_halted(out_halted), .out_status(out_status),
    .fail_count(fail_count), .pending(pending),
    .checked(checked), .flagged(flagged)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: any cycle with a handshake on either side resets it
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // track depth the way the block should, so random ops stay mostly legal
  function automatic void track_depth(input opcode_t op);
    case (op)
      OP_PRINT: if (shadow_depth >= 1) shadow_depth--;
      OP_CONST: if (shadow_depth < STACK_DEPTH_DEF) shadow_depth++;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (shadow_depth >= 2) shadow_depth--;
      default: ;
    endcase
  endfunction

  // one instruction word; gap of 0 keeps push high back to back
  task automatic send_word(input opcode_t op, input logic signed [31:0] cv,
                           input int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_opcode      <= op;
    in_const_value <= cv;
    do @(posedge clk); while (in_full);
    track_depth(op);
    sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return 32'sh0001_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) <<< $urandom_range(0, 8);
    endcase
  endfunction

  // legal-leaning op choice for the current depth
  function automatic opcode_t pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (shadow_depth < 2 && roll < 75) return OP_CONST;
    if (shadow_depth >= STACK_DEPTH_DEF - 2 && roll < 60) return OP_PRINT;
    if (roll < 30) return OP_CONST;
    if (roll < 40) return OP_PRINT;
    if (roll < 47) return OP_NEG;
    if (roll < 97) return opcode_t'($urandom_range(OP_ADD, OP_DIV));
    return OP_HALT;
  endfunction

  // receiver: random pop gaps, quiet stretches, one long hold-off
  initial begin
    int  gap;
    bit  no_idle;
    bit  held;
    held = 1'b0;
    no_idle = 1'b0;
    @(posedge rst_n);
    forever begin
      if (popped % 80 == 0) no_idle = ($urandom_range(0, 3) == 0);
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (!held && popped == 500) begin
        held = 1'b1;
        gap  = HOLD_OFF;
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      popped++;
    end
  end

  initial begin
    opcode_t            dir_op [25];
    logic signed [31:0] dir_val [25];
    int                 gap, mode;
    bit                 no_idle;

    // directed sequence from an empty stack: underflow on print, negate and binary
    // ops, saturation on add, negate, multiply and divide, divide by zero, overflow later
    dir_op = '{OP_HALT, OP_PRINT, OP_NEG, OP_CONST, OP_ADD, OP_CONST, OP_ADD,
               OP_CONST, OP_NEG, OP_SUB, OP_CONST, OP_DIV, OP_CONST, OP_CONST,
               OP_DIV, OP_CONST, OP_MUL, OP_CONST, OP_MUL, OP_CONST, OP_DIV,
               OP_PRINT, OP_PRINT, OP_PRINT, OP_SUB};
    dir_val = '{32'sh0, 32'sh0, 32'sh0, 32'sh7fff_ffff, 32'sh0, 32'sh7fff_ffff,
                32'sh0, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
                32'sh8000_0000, 32'shffff_ffff, 32'sh0, 32'sh0001_8000, 32'sh0,
                32'shffff_8000, 32'sh0, 32'sh0000_0003, 32'sh0, 32'sh0, 32'sh0,
                32'sh0, 32'sh0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_op[i]) send_word(dir_op[i], dir_val[i], $urandom_range(0, 3));

    // random part in blocks: mostly legal programs, some noise, and one
    // block that fills the stack and then pushes past the top
    no_idle = 1'b0;
    for (int blk = 0; sent < N_RANDOM + 25; blk++) begin
      mode    = (blk == 6) ? 2 : ($urandom_range(0, 4) == 0 ? 1 : 0);
      no_idle = ($urandom_range(0, 3) == 0);
      if (mode == 2) begin
        while (shadow_depth < STACK_DEPTH_DEF)
          send_word(OP_CONST, pick_value(), no_idle ? 0 : $urandom_range(0, 2));
        for (int k = 0; k < 4; k++) send_word(OP_CONST, pick_value(), 0);
      end else begin
        for (int k = 0; k < 40; k++) begin
          gap = no_idle ? 0 : $urandom_range(0, 13);
          if (mode == 1) send_word(opcode_t'($urandom_range(0, 7)), $urandom(), gap);
          else send_word(pick_op(), pick_value(), gap);
        end
      end
    end
    in_push <= 1'b0;
    // let the checker log the last accepted word before reading its count
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Executed %0d instruction words (directed corner cases, random programs,",
             sent);
    $display("  a full-stack overflow run); %0d results checked, %0d with error or saturation",
             checked, flagged);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
